[rtl/core/gfd_pkg.sv]
// Shared types and constants for the gyro frame deframer.
`default_nettype none

package gfd_pkg;

  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
  // Payload bytes held in registers; the last payload byte goes straight into the frame record.
  localparam int unsigned STORED_BYTES = FRAME_BYTES - 3;
  localparam int unsigned IDX_W        = (STORED_BYTES > 1) ? $clog2(STORED_BYTES) : 1;

  localparam logic [7:0]       HEADER_BYTE  = 8'hFF;
  localparam logic [15:0]      CSUM_SEED    = 16'hFFFF;
  localparam logic [POS_W-1:0] POS_HUNT     = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR1     = POS_W'(1);
  localparam logic [POS_W-1:0] POS_PAYLOAD  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_BYTES - 1);

  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  typedef struct packed {
    logic [15:0] rate;
    logic [15:0] angle;
    logic [15:0] csum;
  } frame_t;

endpackage

`default_nettype wire

[rtl/core/gfd_collect.sv]
// Header hunt and payload byte collection into a registered frame record.
`default_nettype none

module gfd_collect (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      rx_byte_i,
  output logic                 frm_valid_o,
  input  wire logic            frm_ready_i,
  output gfd_pkg::frame_t      frm_o
);

  logic [gfd_pkg::POS_W-1:0] pos_q, pos_d;
  logic [7:0]                payload_q [gfd_pkg::STORED_BYTES];
  logic [gfd_pkg::IDX_W-1:0] wr_idx;
  logic                      frm_valid_q, frm_valid_d;
  gfd_pkg::frame_t           frm_q;
  logic                      accept;
  logic                      last_byte;
  logic                      store_byte;

  assign in_ready_o = !frm_valid_q || frm_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign last_byte  = accept && (pos_q == gfd_pkg::POS_LAST);
  assign store_byte = accept && (pos_q >= gfd_pkg::POS_PAYLOAD) && (pos_q != gfd_pkg::POS_LAST);
  assign wr_idx     = gfd_pkg::IDX_W'(pos_q - gfd_pkg::POS_PAYLOAD);

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      unique case (pos_q)
        gfd_pkg::POS_HUNT: begin
          pos_d = (rx_byte_i == gfd_pkg::HEADER_BYTE) ? gfd_pkg::POS_HDR1 : gfd_pkg::POS_HUNT;
        end
        gfd_pkg::POS_HDR1: begin
          pos_d = (rx_byte_i == gfd_pkg::HEADER_BYTE) ? gfd_pkg::POS_PAYLOAD
                                                      : gfd_pkg::POS_HUNT;
        end
        gfd_pkg::POS_LAST: begin
          pos_d = gfd_pkg::POS_HUNT;
        end
        default: begin
          pos_d = pos_q + gfd_pkg::POS_W'(1);
        end
      endcase
    end
  end

  assign frm_valid_d = (frm_valid_q && !frm_ready_i) || last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= gfd_pkg::POS_HUNT;
      frm_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      frm_valid_q <= frm_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_byte) begin
      payload_q[wr_idx] <= rx_byte_i;
    end
  end

  // Every payload byte but the last is already held; the last one is the byte on the port.
  always_ff @(posedge clk_i) begin
    if (last_byte) begin
      frm_q.rate  <= {payload_q[1], payload_q[0]};
      frm_q.angle <= {payload_q[3], payload_q[2]};
      frm_q.csum  <= {rx_byte_i, payload_q[4]};
    end
  end

  assign frm_valid_o = frm_valid_q;
  assign frm_o       = frm_q;

endmodule

`default_nettype wire

[rtl/core/gfd_check.sv]
// Checksum test, angle offset capture and the result register.
`default_nettype none

module gfd_check (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               frm_valid_i,
  output logic                    frm_ready_o,
  input  wire gfd_pkg::frame_t    frm_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    frame_status_o,
  output logic signed [15:0]      rate_hundredths_o,
  output logic signed [16:0]      rel_angle_hundredths_o
);

  logic        out_valid_q, out_valid_d;
  logic        status_q, status_d;
  logic [15:0] rate_q, rate_d;
  logic [16:0] rel_q, rel_d;
  logic        offset_valid_q, offset_valid_d;
  logic [15:0] offset_q, offset_d;
  logic        take;
  logic        good;
  logic [15:0] expect_sum;
  logic [15:0] offset_eff;

  assign frm_ready_o = !out_valid_q || out_ready_i;
  assign take        = frm_valid_i && frm_ready_o;

  assign expect_sum = frm_i.rate + frm_i.angle + gfd_pkg::CSUM_SEED;
  assign good       = (frm_i.csum == expect_sum);
  // The first good frame is its own reference, so its relative angle comes out as zero.
  assign offset_eff = offset_valid_q ? offset_q : frm_i.angle;

  always_comb begin
    status_d       = status_q;
    rate_d         = rate_q;
    rel_d          = rel_q;
    offset_valid_d = offset_valid_q;
    offset_d       = offset_q;
    if (take) begin
      if (good) begin
        status_d       = gfd_pkg::STATUS_GOOD;
        rate_d         = frm_i.rate;
        rel_d          = {frm_i.angle[15], frm_i.angle} - {offset_eff[15], offset_eff};
        offset_valid_d = 1'b1;
        offset_d       = offset_eff;
      end else begin
        status_d = gfd_pkg::STATUS_BAD;
        rate_d   = '0;
        rel_d    = '0;
      end
    end
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      offset_valid_q <= 1'b0;
      offset_q       <= '0;
    end else begin
      out_valid_q    <= out_valid_d;
      offset_valid_q <= offset_valid_d;
      offset_q       <= offset_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rate_q   <= rate_d;
    rel_q    <= rel_d;
  end

  assign out_valid_o            = out_valid_q;
  assign frame_status_o         = status_q;
  assign rate_hundredths_o      = $signed(rate_q);
  assign rel_angle_hundredths_o = $signed(rel_q);

endmodule

`default_nettype wire

[rtl/core/gyro_frame_deframer.sv]
// Gyro frame deframer: finds 0xFF 0xFF framed rate/angle records in a byte stream.
// One byte is accepted per cycle whenever the frame record register is free or draining.
// A result follows the last byte of a frame through registers: accepting that byte loads
// the frame record register, and taking the record from there loads the result register.
// Reset clears the frame position to header hunt, drops any pending request and forgets the
// captured angle offset; payload byte registers are not reset.
`default_nettype none

module gyro_frame_deframer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    rx_byte_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic               frame_status_o,
  output logic signed [15:0] rate_hundredths_o,
  output logic signed [16:0] rel_angle_hundredths_o
);

  logic            frm_valid;
  logic            frm_ready;
  gfd_pkg::frame_t frm;

  gfd_collect u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .frm_valid_o (frm_valid),
    .frm_ready_i (frm_ready),
    .frm_o       (frm)
  );

  gfd_check u_check (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .frm_valid_i            (frm_valid),
    .frm_ready_o            (frm_ready),
    .frm_i                  (frm),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .frame_status_o         (frame_status_o),
    .rate_hundredths_o      (rate_hundredths_o),
    .rel_angle_hundredths_o (rel_angle_hundredths_o)
  );

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the gyro frame deframer: byte stream in, rate/angle reports out.
`default_nettype none

module tb_top;

  localparam int RANDOM_ITEMS    = 1650;
  localparam int DIRECTED_ROWS   = 26;
  localparam int PAYLOAD_LEN     = int'(gfd_pkg::FRAME_BYTES) - 2;
  localparam int MAX_GAP         = 8;
  localparam int PRESSURE_AT     = DIRECTED_ROWS + 600;
  localparam int PRESSURE_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 8;

  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  typedef struct packed {
    logic               status;
    logic signed [15:0] rate;
    logic signed [16:0] rel;
  } reading_t;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    reading_t   want;
  } stim_t;

  typedef enum {FR_GOOD, FR_BAD_SUM, FR_TRUNCATED, FR_BROKEN_HDR, FR_NOISE} frame_kind_e;

  localparam reading_t NO_CHECK = '0;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               out_ready_i = 1'b0;
  stim_t              offer       = '0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic               frame_status_o;
  logic signed [15:0] rate_hundredths_o;
  logic signed [16:0] rel_angle_hundredths_o;

  gyro_frame_deframer dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .rx_byte_i              (offer.data),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .frame_status_o         (frame_status_o),
    .rate_hundredths_o      (rate_hundredths_o),
    .rel_angle_hundredths_o (rel_angle_hundredths_o)
  );

  // Directed bytes: a broken header, a bad checksum with full-scale values, the first good
  // frame (carrying 0xFF inside its payload) and a frame that swings the relative angle to
  // its negative limit.
  stim_t directed_tbl [DIRECTED_ROWS] = '{
    '{8'hFF, PREDICTED, NO_CHECK}, '{8'h00, PREDICTED, NO_CHECK},
    '{8'hFF, PREDICTED, NO_CHECK}, '{8'hFF, PREDICTED, NO_CHECK},
    '{8'hFF, PREDICTED, NO_CHECK}, '{8'h7F, PREDICTED, NO_CHECK},
    '{8'h00, PREDICTED, NO_CHECK}, '{8'h80, PREDICTED, NO_CHECK},
    '{8'h00, PREDICTED, NO_CHECK},
    '{8'h00, TYPED, '{gfd_pkg::STATUS_BAD, 16'sd0, 17'sd0}},
    '{8'hFF, PREDICTED, NO_CHECK}, '{8'hFF, PREDICTED, NO_CHECK},
    '{8'h00, PREDICTED, NO_CHECK}, '{8'h80, PREDICTED, NO_CHECK},
    '{8'hFF, PREDICTED, NO_CHECK}, '{8'h7F, PREDICTED, NO_CHECK},
    '{8'hFE, PREDICTED, NO_CHECK},
    '{8'hFF, TYPED, '{gfd_pkg::STATUS_GOOD, 16'sh8000, 17'sd0}},
    '{8'hFF, PREDICTED, NO_CHECK}, '{8'hFF, PREDICTED, NO_CHECK},
    '{8'hFF, PREDICTED, NO_CHECK}, '{8'hFF, PREDICTED, NO_CHECK},
    '{8'h00, PREDICTED, NO_CHECK}, '{8'h80, PREDICTED, NO_CHECK},
    '{8'hFE, PREDICTED, NO_CHECK},
    '{8'h7F, TYPED, '{gfd_pkg::STATUS_GOOD, -16'sd1, -17'sd65535}}
  };

  stim_t    byte_plan[$];
  reading_t expected_readings[$];

  // Shadow of the deframer state.
  logic [gfd_pkg::POS_W-1:0] frame_pos = gfd_pkg::POS_HUNT;
  logic [7:0]                payload [PAYLOAD_LEN];
  logic                      offset_valid = 1'b0;
  logic [15:0]               angle_offset = '0;

  int  mismatches    = 0;
  int  idle_cycles   = 0;
  int  bytes_taken   = 0;
  int  good_frames   = 0;
  int  bad_frames    = 0;
  bit  hold_off_req  = 1'b0;
  bit  hold_off_done = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task report_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t: %s is %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task deframe_byte(input logic [7:0] b, output bit done, output reading_t r);
    logic [15:0] rate, angle, csum, sum;
    done = 1'b0;
    r = '0;
    case (frame_pos)
      gfd_pkg::POS_HUNT: begin
        frame_pos = (b == gfd_pkg::HEADER_BYTE) ? gfd_pkg::POS_HDR1 : gfd_pkg::POS_HUNT;
      end
      gfd_pkg::POS_HDR1: begin
        frame_pos = (b == gfd_pkg::HEADER_BYTE) ? gfd_pkg::POS_PAYLOAD : gfd_pkg::POS_HUNT;
      end
      default: begin
        payload[frame_pos - gfd_pkg::POS_PAYLOAD] = b;
        if (frame_pos != gfd_pkg::POS_LAST) begin
          frame_pos = frame_pos + 1'b1;
        end else begin
          frame_pos = gfd_pkg::POS_HUNT;
          done  = 1'b1;
          rate  = {payload[1], payload[0]};
          angle = {payload[3], payload[2]};
          csum  = {payload[5], payload[4]};
          sum   = gfd_pkg::CSUM_SEED + rate + angle;
          if (csum != sum) begin
            r.status = gfd_pkg::STATUS_BAD;
          end else begin
            // The first good frame sets the zero point of the angle for the rest of the run.
            if (!offset_valid) begin
              angle_offset = angle;
              offset_valid = 1'b1;
            end
            r.status = gfd_pkg::STATUS_GOOD;
            r.rate   = rate;
            r.rel    = {angle[15], angle} - {angle_offset[15], angle_offset};
          end
        end
      end
    endcase
  endtask

  function automatic logic [15:0] pick_word();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 16'h0000;
        1:       return 16'h7FFF;
        2:       return 16'h8000;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom);
  endfunction

  task plan_byte(input logic [7:0] b);
    byte_plan.push_back('{b, PREDICTED, NO_CHECK});
  endtask

  task plan_frame(input frame_kind_e kind, inout int counted);
    logic [15:0] rate, angle, csum;
    logic [7:0]  body [PAYLOAD_LEN];
    int          n;
    rate  = pick_word();
    angle = pick_word();
    csum  = gfd_pkg::CSUM_SEED + rate + angle;
    if (kind == FR_BAD_SUM) csum = csum ^ 16'($urandom_range(1, 65535));
    body = '{rate[7:0], rate[15:8], angle[7:0], angle[15:8], csum[7:0], csum[15:8]};
    case (kind)
      FR_GOOD, FR_BAD_SUM, FR_TRUNCATED: begin
        n = (kind == FR_TRUNCATED) ? $urandom_range(1, PAYLOAD_LEN - 1) : PAYLOAD_LEN;
        plan_byte(gfd_pkg::HEADER_BYTE);
        plan_byte(gfd_pkg::HEADER_BYTE);
        for (int i = 0; i < n; i++) plan_byte(body[i]);
        counted += n + 2;
      end
      FR_BROKEN_HDR: begin
        plan_byte(gfd_pkg::HEADER_BYTE);
        plan_byte(8'($urandom_range(0, 254)));
        counted += 2;
      end
      default: begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) plan_byte(8'($urandom));
      end
    endcase
  endtask

  // Mostly idle gaps of random length, with occasional stretches of back-to-back traffic.
  task automatic draw_gap(inout int calm, output int gap);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if ($urandom_range(0, 29) == 0) begin
      calm = $urandom_range(16, 48);
      gap  = 0;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
    end
  endtask

  always @(posedge clk_i) begin
    reading_t got, want, predicted;
    bit       done, moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        got = '{frame_status_o, rate_hundredths_o, rel_angle_hundredths_o};
        if (got.status == gfd_pkg::STATUS_GOOD) good_frames++;
        else bad_frames++;
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected result, status", got.status, -1);
        end else begin
          want = expected_readings.pop_front();
          if (got.status !== want.status)
            report_mismatch("frame_status", got.status, want.status);
          if (got.rate !== want.rate)
            report_mismatch("rate_hundredths", $signed(got.rate), $signed(want.rate));
          if (got.rel !== want.rel)
            report_mismatch("rel_angle_hundredths", $signed(got.rel), $signed(want.rel));
        end
      end
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        bytes_taken++;
        deframe_byte(offer.data, done, predicted);
        if (done) expected_readings.push_back(offer.typed ? offer.want : predicted);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk_i); while (idle_cycles < WATCHDOG_LIMIT);
    $display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : receiver
    int recv_calm, stall;
    recv_calm = 0;
    forever begin
      // One long hold-off lets the sender fill the block until it refuses input.
      if (hold_off_req && !hold_off_done) begin
        stall = PRESSURE_CYCLES;
        hold_off_done = 1'b1;
      end else begin
        draw_gap(recv_calm, stall);
      end
      out_ready_i <= (stall == 0);
      if (stall > 0) begin
        repeat (stall) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  initial begin : sender
    int          send_calm, gap, counted, pick;
    frame_kind_e kind;
    send_calm = 0;
    counted   = 0;
    foreach (directed_tbl[i]) byte_plan.push_back(directed_tbl[i]);
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65)      kind = FR_GOOD;
      else if (pick < 80) kind = FR_BAD_SUM;
      else if (pick < 88) kind = FR_TRUNCATED;
      else if (pick < 94) kind = FR_BROKEN_HDR;
      else                kind = FR_NOISE;
      plan_frame(kind, counted);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < byte_plan.size(); i++) begin
      draw_gap(send_calm, gap);
      if (i == PRESSURE_AT) hold_off_req = 1'b1;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      offer      <= byte_plan[i];
      do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Fed %0d bytes; got %0d good frames and %0d checksum errors back.",
             bytes_taken, good_frames, bad_frames);
    $display("Output held off for %0d cycles once to back up the input; %0d mismatches.",
             PRESSURE_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
